[rtl/prbs_pkg.sv]
// Shared constants and tap helpers for the PRBS pattern checker.
package prbs_pkg;

    localparam int unsigned LFSR_W   = 31;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned SEL_W    = 3;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    typedef logic [LFSR_W-1:0] lfsr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SEL_W-1:0]  sel_t;

    // Polynomial selector codes
    localparam sel_t SEL_N7  = 3'd0;
    localparam sel_t SEL_N9  = 3'd1;
    localparam sel_t SEL_N11 = 3'd2;
    localparam sel_t SEL_N15 = 3'd3;
    localparam sel_t SEL_N23 = 3'd4;
    localparam sel_t SEL_N31 = 3'd5;

    // Register address of poly_select
    localparam logic [APB_AW-1:0] ADDR_POLY_SELECT = 3'd0;

    // Sequence order N; unused codes fall back to PRBS31.
    function automatic cnt_t poly_order(input sel_t sel);
        cnt_t n;
        case (sel)
            SEL_N7:  n = 5'd7;
            SEL_N9:  n = 5'd9;
            SEL_N11: n = 5'd11;
            SEL_N15: n = 5'd15;
            SEL_N23: n = 5'd23;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    // Next sequence bit: XOR of the two tap cells, cell 0 newest.
    function automatic logic gen_bit(input lfsr_t q, input sel_t sel);
        logic g;
        case (sel)
            SEL_N7:  g = q[6]  ^ q[5];
            SEL_N9:  g = q[8]  ^ q[4];
            SEL_N11: g = q[10] ^ q[8];
            SEL_N15: g = q[14] ^ q[13];
            SEL_N23: g = q[22] ^ q[17];
            default: g = q[30] ^ q[27];
        endcase
        return g;
    endfunction

endpackage

[rtl/prbs_pattern_checker_top.sv]
// Top level of the PRBS pattern checker: cell chain, seed control, output stage.
//
// PRBS pattern checker. Each transaction on the input channel carries one
// received bit (data_bit) and a record_start flag; each produces exactly one
// result transaction carrying bit_error and seeding. The block accepts one bit
// per clock while in_stall is low: the shift chain of 31 one-bit cells advances
// once per accepted transaction, and the next bit can enter in the following
// cycle. out_valid comes from the single output register, loaded on acceptance;
// in_stall is raised only while that register holds a result that the
// downstream side stalls. poly_select (APB address 0) picks PRBS-7, 9, 11,
// 15, 23 or 31 (codes 6 and 7 act as PRBS-31). After reset or a record_start,
// the first N bits load the chain as seed (seeding=1, bit_error=0); after
// that the chain runs free on its taps and each received bit is compared
// with the generated bit. Write poly_select only while the block is idle.
module prbs_pattern_checker_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          data_bit,
    input  logic                          record_start,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          bit_error,
    output logic                          seeding,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prbs_pkg::APB_AW-1:0]   paddr,
    input  logic [prbs_pkg::APB_DW-1:0]   pwdata,
    output logic [prbs_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    prbs_pkg::sel_t  poly_select_reg;
    prbs_pkg::cnt_t  seed_count_reg;
    prbs_pkg::cnt_t  seed_count_next;
    prbs_pkg::cnt_t  order;
    prbs_pkg::cnt_t  count_eff;
    prbs_pkg::lfsr_t lfsr_q;
    prbs_pkg::lfsr_t lfsr_d;

    logic out_valid_reg;
    logic out_valid_next;
    logic bit_error_reg;
    logic bit_error_next;
    logic seeding_reg;
    logic seeding_next;

    logic in_accept;
    logic cfg_write;
    logic seed_now;
    logic gen;
    logic chain_in;

    // ---------------------------------------------------------------
    // Configuration: single register, always ready.
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == prbs_pkg::ADDR_POLY_SELECT)
                       ? {{(prbs_pkg::APB_DW-prbs_pkg::SEL_W){1'b0}}, poly_select_reg}
                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_select_reg <= prbs_pkg::SEL_N7;
        end
        else if (cfg_write && (paddr == prbs_pkg::ADDR_POLY_SELECT))
        begin
            poly_select_reg <= pwdata[prbs_pkg::SEL_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Handshake: take a new bit whenever the output register is free
    // or is being emptied in this cycle.
    // ---------------------------------------------------------------
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // ---------------------------------------------------------------
    // Seed control: record_start restarts the count, and seeding lasts
    // while the count is below the order selected now.
    // ---------------------------------------------------------------
    assign order     = prbs_pkg::poly_order(poly_select_reg);
    assign count_eff = record_start ? '0 : seed_count_reg;
    assign seed_now  = (count_eff < order);
    assign gen       = prbs_pkg::gen_bit(lfsr_q, poly_select_reg);
    assign chain_in  = seed_now ? data_bit : gen;

    assign seed_count_next = seed_now ? count_eff + 5'd1 : count_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_count_reg <= '0;
        end
        else if (in_accept)
        begin
            seed_count_reg <= seed_count_next;
        end
    end

    // ---------------------------------------------------------------
    // Shift chain: cell 0 takes the seed or generated bit, each other
    // cell takes its lower neighbor.
    // ---------------------------------------------------------------
    assign lfsr_d = {lfsr_q[prbs_pkg::LFSR_W-2:0], chain_in};

    for (genvar i = 0; i < prbs_pkg::LFSR_W; i++)
    begin : g_cell
        prbs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (in_accept),
            .d        (lfsr_d[i]),
            .q        (lfsr_q[i])
        );
    end

    // ---------------------------------------------------------------
    // Output register: load on accept, drop when taken.
    // ---------------------------------------------------------------
    assign out_valid_next = in_accept || (out_valid_reg && out_stall);
    assign bit_error_next = seed_now ? 1'b0 : (gen ^ data_bit);
    assign seeding_next   = seed_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            bit_error_reg <= bit_error_next;
            seeding_reg   <= seeding_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign bit_error = bit_error_reg;
    assign seeding   = seeding_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_error_while_seeding: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(seeding && bit_error)
    ) else $error("bit_error raised on a seed bit");

    a_restart_count: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_accept && record_start) |=> (seed_count_reg == 5'd1)
    ) else $error("record_start did not restart the seed count");

    a_accept_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg
    ) else $error("accepted transaction produced no result");

    a_seed_bit_loaded: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_accept && seed_now) |=> (lfsr_q[0] == $past(data_bit))
    ) else $error("seed bit not loaded into cell 0");

endmodule

[rtl/prbs_cell.sv]
// One stage of the PRBS shift chain: holds one sequence bit.
module prbs_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic shift_en,
    input  logic d,
    output logic q
);

    logic q_reg;
    logic q_next;

    // Take the neighbor's bit on a shift, hold otherwise.
    assign q_next = shift_en ? d : q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= 1'b0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
